// ----- rtl/core/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared assertion macros; expect clk and rst_n in scope at the point of use.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge, disabled while reset is held.
`define CWB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that an antecedent is followed by a consequent in the next cycle.
`define CWB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/core/cwb_pkg.sv -----
// ----------------------------------------------------------------------------
// cwb_pkg
// Types, constants and helper functions for the circle and wall bounce block.
// ----------------------------------------------------------------------------
package cwb_pkg;

  localparam int CORDIC_STEPS_DEF = 16;
  localparam int NORM_STAGES      = 6;
  localparam int VW               = 36;  // vectoring x/y width
  localparam int UW               = 34;  // unit vector width, Q1.31 plus guard
  localparam int DW               = 34;  // normalized difference width
  localparam int CFG_AW           = 4;
  localparam int NUM_REGS         = 4;

  localparam logic [30:0] WALL_RADIUS_MAX = 31'd655;

  // Register indexes
  localparam logic [1:0] REG_LEFT   = 2'd0;
  localparam logic [1:0] REG_RIGHT  = 2'd1;
  localparam logic [1:0] REG_TOP    = 2'd2;
  localparam logic [1:0] REG_BOTTOM = 2'd3;

  typedef enum logic [2:0] {
    KIND_CIRCLE = 3'd0,
    KIND_LEFT   = 3'd1,
    KIND_RIGHT  = 3'd2,
    KIND_TOP    = 3'd3,
    KIND_BOTTOM = 3'd4,
    KIND_NONE   = 3'd5
  } bounce_kind_t;

  typedef struct packed {
    logic              wall;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic [30:0]        r;
  } item_t;

  typedef struct packed {
    item_t              itm;
    logic signed [DW-1:0] dx;
    logic signed [DW-1:0] dy;
  } norm_t;

  typedef struct packed {
    item_t              itm;
    logic               zero;
    logic               fold;
    logic signed [VW-1:0] x;
    logic signed [VW-1:0] y;
    logic signed [UW-1:0] rx;
    logic signed [UW-1:0] ry;
  } cordic_t;

  typedef struct packed {
    logic signed [31:0] new_pos_x;
    logic signed [31:0] new_pos_y;
    logic signed [31:0] new_vel_x;
    logic signed [31:0] new_vel_y;
    bounce_kind_t       kind;
  } result_t;

  // Clamp a wide value to the int32 range.
  function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
    logic signed [31:0] res;
    if (v > 40'sd2147483647) res = 32'sh7FFF_FFFF;
    else if (v < -40'sd2147483648) res = 32'sh8000_0000;
    else res = v[31:0];
    return res;
  endfunction

  // Negate with saturation of the most negative value.
  function automatic logic signed [31:0] neg_sat32(input logic signed [31:0] v);
    logic signed [31:0] res;
    if (v == 32'sh8000_0000) res = 32'sh7FFF_FFFF;
    else res = -v;
    return res;
  endfunction

  // Unsigned floor quotient by restoring long division, elaboration only.
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] q;
    logic [64:0] rem;
    q   = '0;
    rem = '0;
    for (int k = 63; k >= 0; k--) begin
      rem = {rem[63:0], num[k]};
      if (rem >= {1'b0, den}) begin
        rem  = rem - {1'b0, den};
        q[k] = 1'b1;
      end
    end
    return q;
  endfunction

  // Inverse CORDIC gain in Q1.31, evaluated at elaboration.
  function automatic logic [63:0] inv_gain_q31(input int steps);
    logic [63:0] p;
    logic [63:0] n;
    logic [63:0] r;
    logic [63:0] b;
    p = 64'h4000_0000_0000_0000;
    for (int i = 0; i < steps; i++) begin
      p = p - udiv64(p, (64'd1 << (2 * i)) + 64'd1);
    end
    n = p;
    r = '0;
    b = 64'h4000_0000_0000_0000;
    for (int k = 0; k < 32; k++) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

endpackage

// ----- rtl/core/circle_and_wall_bounce.sv -----
// An item passes the input register, normalization cells, CORDIC cells and reflect stages.
// One item per cycle unless stalled; every stage is a register with its own valid bit.
// Depth is set by the CORDIC cell row, one cell per micro-rotation.
// A stalled output holds only the stages behind it; bubbles in front still fill.
// Synchronous active-low reset clears all valid bits and sets every bound to 0.
// ----------------------------------------------------------------------------
// circle_and_wall_bounce
// Projectile bounce off a hit circle or the arena edge, Q15.16 fixed point.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module circle_and_wall_bounce
  import cwb_pkg::*;
#(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  // input stream
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [223:0]      in_tdata,   // pos_x, pos_y, vel_x, vel_y, centre_x, centre_y, radius
  input  logic [0:0]        in_tuser,   // op
  // result stream
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [127:0]      out_tdata,  // new_pos_x, new_pos_y, new_vel_x, new_vel_y
  output logic [2:0]        out_tuser,  // bounce_kind
  // configuration
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [31:0]       cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready
);

  localparam logic signed [UW-1:0] KINV = UW'(inv_gain_q31(CORDIC_STEPS));

  logic signed [31:0] bound_r [NUM_REGS];
  logic               cfg_wr;

  logic   in_v_r;
  norm_t  in_d_r;
  item_t  in_itm;

  logic   nv [NORM_STAGES+1];
  logic   nr [NORM_STAGES+1];
  norm_t  nd [NORM_STAGES+1];

  logic    cv [CORDIC_STEPS+1];
  logic    cr [CORDIC_STEPS+1];
  cordic_t cd [CORDIC_STEPS+1];

  result_t res;

  // Configuration registers
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = bound_r[cfg_paddr[3:2]];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_REGS; i++) bound_r[i] <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[3:2])
        REG_LEFT:   bound_r[REG_LEFT]   <= cfg_pwdata;
        REG_RIGHT:  bound_r[REG_RIGHT]  <= cfg_pwdata;
        REG_TOP:    bound_r[REG_TOP]    <= cfg_pwdata;
        REG_BOTTOM: bound_r[REG_BOTTOM] <= cfg_pwdata;
        default:    ;
      endcase
    end
  end

  // Input stage: unpack, pick the wall path, form the difference
  always_comb begin
    in_itm.wall = !in_tuser[0] && (in_tdata[222:192] <= WALL_RADIUS_MAX);
    in_itm.px   = in_tdata[31:0];
    in_itm.py   = in_tdata[63:32];
    in_itm.vx   = in_tdata[95:64];
    in_itm.vy   = in_tdata[127:96];
    in_itm.cx   = in_tdata[159:128];
    in_itm.cy   = in_tdata[191:160];
    in_itm.r    = in_tdata[222:192];
  end

  assign in_tready = !in_v_r || nr[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_tready) begin
      in_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_d_r.itm <= in_itm;
      in_d_r.dx  <= DW'(in_itm.px) - DW'(in_itm.cx);
      in_d_r.dy  <= DW'(in_itm.py) - DW'(in_itm.cy);
    end
  end

  assign nv[0] = in_v_r;
  assign nd[0] = in_d_r;

  // Normalize by 32, 16, 8, 4, 2, 1
  for (genvar k = 0; k < NORM_STAGES; k++) begin : g_norm
    cwb_norm_cell #(.SHIFT(32 >> k)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .in_valid (nv[k]),
      .in_ready (nr[k]),
      .in_data  (nd[k]),
      .out_valid(nv[k+1]),
      .out_ready(nr[k+1]),
      .out_data (nd[k+1])
    );
  end

  // Fold into the right half plane, seed the unit vector with the inverse gain
  always_comb begin
    cd[0].itm  = nd[NORM_STAGES].itm;
    cd[0].zero = (nd[NORM_STAGES].dx == '0) && (nd[NORM_STAGES].dy == '0);
    cd[0].fold = nd[NORM_STAGES].dx[DW-1];
    cd[0].x    = cd[0].fold ? -VW'(nd[NORM_STAGES].dx) : VW'(nd[NORM_STAGES].dx);
    cd[0].y    = cd[0].fold ? -VW'(nd[NORM_STAGES].dy) : VW'(nd[NORM_STAGES].dy);
    cd[0].rx   = KINV;
    cd[0].ry   = '0;
  end

  assign cv[0]            = nv[NORM_STAGES];
  assign nr[NORM_STAGES]  = cr[0];

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
    cwb_cordic_cell #(.SHIFT(i)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .in_valid (cv[i]),
      .in_ready (cr[i]),
      .in_data  (cd[i]),
      .out_valid(cv[i+1]),
      .out_ready(cr[i+1]),
      .out_data (cd[i+1])
    );
  end

  cwb_reflect u_reflect (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (cv[CORDIC_STEPS]),
    .in_ready    (cr[CORDIC_STEPS]),
    .in_data     (cd[CORDIC_STEPS]),
    .left_bound  (bound_r[REG_LEFT]),
    .right_bound (bound_r[REG_RIGHT]),
    .top_bound   (bound_r[REG_TOP]),
    .bottom_bound(bound_r[REG_BOTTOM]),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_data    (res)
  );

  assign out_tdata = {res.new_vel_y, res.new_vel_x, res.new_pos_y, res.new_pos_x};
  assign out_tuser = res.kind;

  `CWB_ASSERT_NEXT(a_cfg_left_lands, cfg_wr && (cfg_paddr[3:2] == REG_LEFT),
    bound_r[REG_LEFT] == $past(cfg_pwdata), "left bound write lost")
  `CWB_ASSERT(a_kind_range, !out_tvalid || (out_tuser <= KIND_NONE),
    "bounce kind out of range")
  `CWB_ASSERT_NEXT(a_input_captured, in_tvalid && in_tready, in_v_r,
    "accepted item not held in input stage")

endmodule

// ----- rtl/core/cwb_norm_cell.sv -----
// ----------------------------------------------------------------------------
// cwb_norm_cell
// One normalization step: shift the difference left by SHIFT if it still fits.
// ----------------------------------------------------------------------------
module cwb_norm_cell
  import cwb_pkg::*;
#(
  parameter int SHIFT = 1
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  norm_t in_data,
  output logic  out_valid,
  input  logic  out_ready,
  output norm_t out_data
);

  logic            valid_r;
  norm_t           data_r;
  norm_t           data_nxt;
  logic [DW-1:0]   ax;
  logic [DW-1:0]   ay;
  logic [DW-2:0]   mag;
  logic            fits;

  // Shift only while the larger magnitude stays below 2^33
  always_comb begin
    ax       = in_data.dx[DW-1] ? DW'(-in_data.dx) : in_data.dx;
    ay       = in_data.dy[DW-1] ? DW'(-in_data.dy) : in_data.dy;
    mag      = ax[DW-2:0] | ay[DW-2:0];
    fits     = (mag >> (DW - 1 - SHIFT)) == '0;
    data_nxt = in_data;
    if (fits) begin
      data_nxt.dx = in_data.dx <<< SHIFT;
      data_nxt.dy = in_data.dy <<< SHIFT;
    end
  end

  assign in_ready = !valid_r || out_ready;

  // Advance on a transfer, hold on a stall
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

// ----- rtl/core/cwb_cordic_cell.sv -----
// ----------------------------------------------------------------------------
// cwb_cordic_cell
// One CORDIC step: a vectoring micro-rotation and its replay on the unit vector.
// ----------------------------------------------------------------------------
module cwb_cordic_cell
  import cwb_pkg::*;
#(
  parameter int SHIFT = 0
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  input  cordic_t in_data,
  output logic    out_valid,
  input  logic    out_ready,
  output cordic_t out_data
);

  logic    valid_r;
  cordic_t data_r;
  cordic_t data_nxt;
  logic    cw;

  // Rotate the vector toward the x axis, replay the opposite turn on the unit vector
  always_comb begin
    cw       = in_data.y > 0;
    data_nxt = in_data;
    if (cw) begin
      data_nxt.x  = in_data.x + (in_data.y >>> SHIFT);
      data_nxt.y  = in_data.y - (in_data.x >>> SHIFT);
      data_nxt.rx = in_data.rx - (in_data.ry >>> SHIFT);
      data_nxt.ry = in_data.ry + (in_data.rx >>> SHIFT);
    end else begin
      data_nxt.x  = in_data.x - (in_data.y >>> SHIFT);
      data_nxt.y  = in_data.y + (in_data.x >>> SHIFT);
      data_nxt.rx = in_data.rx + (in_data.ry >>> SHIFT);
      data_nxt.ry = in_data.ry - (in_data.rx >>> SHIFT);
    end
  end

  assign in_ready = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

// ----- rtl/core/cwb_reflect.sv -----
// ----------------------------------------------------------------------------
// cwb_reflect
// Snap the position onto the circle, reflect the velocity, or bounce off a wall.
// ----------------------------------------------------------------------------
module cwb_reflect
  import cwb_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  cordic_t            in_data,
  input  logic signed [31:0] left_bound,
  input  logic signed [31:0] right_bound,
  input  logic signed [31:0] top_bound,
  input  logic signed [31:0] bottom_bound,
  output logic               out_valid,
  input  logic               out_ready,
  output result_t            out_data
);

  localparam int NS = 5;

  typedef struct packed {
    item_t                itm;
    logic signed [UW-1:0] ux;
    logic signed [UW-1:0] uy;
  } s1_t;

  typedef struct packed {
    item_t              itm;
    logic signed [UW-1:0] ux;
    logic signed [UW-1:0] uy;
    logic signed [65:0] prx;
    logic signed [65:0] pry;
    logic signed [65:0] pvx;
    logic signed [65:0] pvy;
  } s2_t;

  typedef struct packed {
    item_t              itm;
    logic signed [UW-1:0] ux;
    logic signed [UW-1:0] uy;
    logic signed [31:0] npx;
    logic signed [31:0] npy;
    logic signed [34:0] p;
  } s3_t;

  typedef struct packed {
    item_t              itm;
    logic signed [31:0] npx;
    logic signed [31:0] npy;
    logic signed [68:0] pux;
    logic signed [68:0] puy;
  } s4_t;

  logic [NS-1:0] valid_r;
  logic [NS-1:0] rdy;
  logic [NS-1:0] ld;
  logic [NS-1:0] vin;

  s1_t     s1_r, s1_nxt;
  s2_t     s2_r, s2_nxt;
  s3_t     s3_r, s3_nxt;
  s4_t     s4_r, s4_nxt;
  result_t s5_r, s5_nxt;

  logic signed [65:0] ofs_x, ofs_y;
  logic signed [66:0] dot;
  logic signed [68:0] cor_x, cor_y;

  // Ready ripples back from the output register
  always_comb begin
    rdy[NS-1] = !valid_r[NS-1] || out_ready;
    for (int k = NS - 2; k >= 0; k--) begin
      rdy[k] = !valid_r[k] || rdy[k+1];
    end
    vin = {valid_r[NS-2:0], in_valid};
    ld  = vin & rdy;
  end

  assign in_ready = rdy[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      for (int k = 0; k < NS; k++) begin
        if (rdy[k]) valid_r[k] <= vin[k];
      end
    end
  end

  // Stage 1: undo the fold, force (1,0) for a coincident centre
  always_comb begin
    s1_nxt.itm = in_data.itm;
    if (in_data.zero) begin
      s1_nxt.ux = UW'(34'sh0_8000_0000);
      s1_nxt.uy = '0;
    end else if (in_data.fold) begin
      s1_nxt.ux = -in_data.rx;
      s1_nxt.uy = -in_data.ry;
    end else begin
      s1_nxt.ux = in_data.rx;
      s1_nxt.uy = in_data.ry;
    end
  end

  // Stage 2: radius and velocity products
  always_comb begin
    s2_nxt.itm = s1_r.itm;
    s2_nxt.ux  = s1_r.ux;
    s2_nxt.uy  = s1_r.uy;
    s2_nxt.prx = $signed({1'b0, s1_r.itm.r}) * s1_r.ux;
    s2_nxt.pry = $signed({1'b0, s1_r.itm.r}) * s1_r.uy;
    s2_nxt.pvx = s1_r.itm.vx * s1_r.ux;
    s2_nxt.pvy = s1_r.itm.vy * s1_r.uy;
  end

  // Stage 3: snapped position and rounded projection
  always_comb begin
    ofs_x      = (s2_r.prx + (66'sd1 <<< 30)) >>> 31;
    ofs_y      = (s2_r.pry + (66'sd1 <<< 30)) >>> 31;
    dot        = (67'(s2_r.pvx) + 67'(s2_r.pvy) + (67'sd1 <<< 30)) >>> 31;
    s3_nxt.itm = s2_r.itm;
    s3_nxt.ux  = s2_r.ux;
    s3_nxt.uy  = s2_r.uy;
    s3_nxt.npx = sat32(40'(s2_r.itm.cx) + 40'(ofs_x));
    s3_nxt.npy = sat32(40'(s2_r.itm.cy) + 40'(ofs_y));
    s3_nxt.p   = 35'(dot);
  end

  // Stage 4: correction products
  always_comb begin
    s4_nxt.itm = s3_r.itm;
    s4_nxt.npx = s3_r.npx;
    s4_nxt.npy = s3_r.npy;
    s4_nxt.pux = s3_r.p * s3_r.ux;
    s4_nxt.puy = s3_r.p * s3_r.uy;
  end

  // Stage 5: reflected velocity, or the wall crossed, checked left, right, top, bottom in order
  always_comb begin
    cor_x = (s4_r.pux + (69'sd1 <<< 29)) >>> 30;
    cor_y = (s4_r.puy + (69'sd1 <<< 29)) >>> 30;
    s5_nxt.new_pos_x = s4_r.itm.px;
    s5_nxt.new_pos_y = s4_r.itm.py;
    s5_nxt.new_vel_x = s4_r.itm.vx;
    s5_nxt.new_vel_y = s4_r.itm.vy;
    s5_nxt.kind      = KIND_NONE;
    if (!s4_r.itm.wall) begin
      s5_nxt.new_pos_x = s4_r.npx;
      s5_nxt.new_pos_y = s4_r.npy;
      s5_nxt.new_vel_x = sat32(40'(s4_r.itm.vx) - 40'(cor_x));
      s5_nxt.new_vel_y = sat32(40'(s4_r.itm.vy) - 40'(cor_y));
      s5_nxt.kind      = KIND_CIRCLE;
    end else begin
      priority if (s4_r.itm.px <= left_bound) begin
        s5_nxt.new_pos_x = left_bound;
        s5_nxt.new_vel_x = neg_sat32(s4_r.itm.vx);
        s5_nxt.kind      = KIND_LEFT;
      end else if (s4_r.itm.px >= right_bound) begin
        s5_nxt.new_pos_x = right_bound;
        s5_nxt.new_vel_x = neg_sat32(s4_r.itm.vx);
        s5_nxt.kind      = KIND_RIGHT;
      end else if (s4_r.itm.py <= top_bound) begin
        s5_nxt.new_pos_y = top_bound;
        s5_nxt.new_vel_y = neg_sat32(s4_r.itm.vy);
        s5_nxt.kind      = KIND_TOP;
      end else if (s4_r.itm.py >= bottom_bound) begin
        s5_nxt.new_pos_y = bottom_bound;
        s5_nxt.new_vel_y = neg_sat32(s4_r.itm.vy);
        s5_nxt.kind      = KIND_BOTTOM;
      end else begin
        s5_nxt.kind      = KIND_NONE;
      end
    end
  end

  // Payload registers, loaded on each stage transfer
  always_ff @(posedge clk) begin
    if (ld[0]) s1_r <= s1_nxt;
    if (ld[1]) s2_r <= s2_nxt;
    if (ld[2]) s3_r <= s3_nxt;
    if (ld[3]) s4_r <= s4_nxt;
    if (ld[4]) s5_r <= s5_nxt;
  end

  assign out_valid = valid_r[NS-1];
  assign out_data  = s5_r;

endmodule
